### rtl/akt_pkg.sv
// Shared types and codes for the allowlist key table.
// Used by akt_cell, allowlist_key_table_core and akt_checker.
`default_nettype none
package akt_pkg;

  localparam int KEY_W = 22;
  localparam int CNT_W = 7;
  localparam int ACT_W = 2;
  localparam int ST_W  = 2;

  localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_CHECK   = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_REPLACE = 2'd2
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] replacement_key;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  // Request walking down the row of cells.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] replacement_key;
  } cell_token_t;

  // Table-wide control broadcast to every cell.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             insert_ok;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/akt_cell.sv
// One entry of the allowlist key table: stored key, compare and update.
// Depends on akt_pkg for the token and control types.
`default_nettype none
module akt_cell #(
  parameter int IDX = 0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  akt_pkg::cell_ctl_t  ctl,
  input  akt_pkg::cell_token_t tok_in,
  output akt_pkg::cell_token_t tok_out
);

  localparam bit IDX_FITS = (IDX < (2 ** akt_pkg::CNT_W));
  localparam logic [akt_pkg::CNT_W-1:0] IDX_C = akt_pkg::CNT_W'(IDX);

  logic [akt_pkg::KEY_W-1:0] stored;
  logic in_use;
  logic is_tail;
  logic hit;
  logic do_replace;
  logic do_insert;

  always_comb begin
    in_use     = IDX_FITS && (ctl.count > IDX_C);
    is_tail    = IDX_FITS && (ctl.count == IDX_C);
    hit        = in_use && (stored == tok_in.key);
    do_replace = tok_in.valid && hit && !tok_in.found &&
                 (tok_in.action == akt_pkg::ACT_REPLACE);
    do_insert  = tok_in.valid && is_tail && !tok_in.found && ctl.insert_ok &&
                 (tok_in.action == akt_pkg::ACT_INSERT);
  end

  // Key store entry: written only on an insert at the tail or a first-match replace.
  always_ff @(posedge clk) begin
    if (do_replace) begin
      stored <= tok_in.replacement_key;
    end else if (do_insert) begin
      stored <= tok_in.key;
    end
  end

  // Advance the request one cell per cycle; carry the match flag along.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.found           <= tok_in.found | hit;
    tok_out.action          <= tok_in.action;
    tok_out.key             <= tok_in.key;
    tok_out.replacement_key <= tok_in.replacement_key;
  end

endmodule
`default_nettype wire

### rtl/allowlist_key_table_core.sv
// Allowlist key table top level: input/output channels, APB register, cell row.
// Depends on akt_pkg and akt_cell.
// Usage:
//   A request (action, key, replacement_key) is a transfer on the in channel
//   (in_valid high, in_stall low). It answers with exactly one transfer on the
//   out channel carrying status and the entry count after the request.
//   The request walks a row of TABLE_DEPTH cells, one cell per cycle. Each
//   cell holds one key, compares it when it lies below the entry count, and
//   rewrites itself on the first matching replace or on an insert at the tail.
//   out_valid and the result are registered at the end of the cell row, once
//   the request has walked every cell.
//   One request is in flight at a time and in_stall drops the cycle after the
//   result transfer, so a new request is taken only once the last result has
//   been accepted, however long that result waits under out_stall.
//   When the receiver stalls, the result is held unchanged in the output register.
//   Reset (synchronous, rst high) clears the entry count to zero, sets
//   capacity_limit to 64 and drops any request in flight; stored keys are not
//   cleared, and entries at or above the count are never compared.
//   capacity_limit sits at byte address 0 of the APB port; write it only while
//   no request is in flight.
`default_nettype none
module allowlist_key_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire                clk,
  input  wire                rst,
  // request channel
  input  wire                in_valid,
  output logic               in_stall,
  input  akt_pkg::in_item_t  in_data,
  // result channel
  output logic               out_valid,
  input  wire                out_stall,
  output akt_pkg::out_item_t out_data,
  // configuration port
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic REG_CAPACITY = 1'b0;

  logic [akt_pkg::CNT_W-1:0] capacity_limit;
  logic [akt_pkg::CNT_W-1:0] valid_count;
  logic                      in_flight;
  logic                      in_xfer;
  logic                      out_xfer;
  logic                      insert_ok;
  logic                      insert_done;
  logic [akt_pkg::ST_W-1:0]  status_next;

  akt_pkg::cell_ctl_t   ctl;
  akt_pkg::cell_token_t tok [0:TABLE_DEPTH];

  // Configuration port: zero wait states, single register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= akt_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      capacity_limit <= pwdata[akt_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(32 - akt_pkg::CNT_W){1'b0}}, capacity_limit};
    end
  end

  // Handshakes: hold off new requests until the current result is taken.
  assign in_stall = in_flight;
  assign in_xfer  = in_valid && !in_flight;
  assign out_xfer = out_valid && !out_stall;

  // Room for one more entry under both the register and the built depth.
  assign insert_ok = (valid_count < capacity_limit) &&
                     (32'(valid_count) < 32'(TABLE_DEPTH));

  assign ctl.count     = valid_count;
  assign ctl.insert_ok = insert_ok;

  // Head of the row: launch the request on its input transfer.
  always_comb begin
    tok[0].valid           = in_xfer;
    tok[0].found           = 1'b0;
    tok[0].action          = in_data.action;
    tok[0].key             = in_data.key;
    tok[0].replacement_key = in_data.replacement_key;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    akt_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Tail of the row: the match flag now covers every entry in use.
  always_comb begin
    insert_done = 1'b0;
    case (tok[TABLE_DEPTH].action)
      akt_pkg::ACT_INSERT: begin
        if (tok[TABLE_DEPTH].found) begin
          status_next = akt_pkg::ST_DUP;
        end else if (insert_ok) begin
          status_next = akt_pkg::ST_OK;
          insert_done = 1'b1;
        end else begin
          status_next = akt_pkg::ST_FULL;
        end
      end
      default: begin
        // Check, replace and the unused code report presence the same way.
        status_next = tok[TABLE_DEPTH].found ? akt_pkg::ST_OK : akt_pkg::ST_ABSENT;
      end
    endcase
  end

  // Count update and request tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count <= '0;
      in_flight   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (tok[TABLE_DEPTH].valid && insert_done) begin
        valid_count <= valid_count + akt_pkg::CNT_W'(1);
      end
      if (in_xfer) begin
        in_flight <= 1'b1;
      end else if (out_xfer) begin
        in_flight <= 1'b0;
      end
      if (tok[TABLE_DEPTH].valid) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register: load once at the end of the walk, hold while stalled.
  always_ff @(posedge clk) begin
    if (tok[TABLE_DEPTH].valid) begin
      out_data.status      <= status_next;
      out_data.entry_count <= insert_done ? (valid_count + akt_pkg::CNT_W'(1))
                                          : valid_count;
    end
  end

endmodule
`default_nettype wire

### rtl/akt_checker.sv
// Port-level checks for allowlist_key_table_core, bound to the top level.
// Depends on akt_pkg for the channel payload types.
`default_nettype none
module akt_checker (
  input wire                clk,
  input wire                rst,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input akt_pkg::out_item_t out_data
);

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // One request at a time: a transfer in closes the input side.
  a_single_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open while a request is in flight");

  // A waiting result keeps the input side closed.
  a_result_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind allowlist_key_table_core akt_checker u_akt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

### test/allowlist_key_table_core_tb.sv
// Self-checking testbench for allowlist_key_table_core: random and directed requests,
// an in-bench table predictor, and APB writes of the capacity register between phases.
// Depends on akt_pkg and the allowlist_key_table_core RTL.
`timescale 1ns / 1ps
module allowlist_key_table_core_tb;

  localparam int TABLE_DEPTH = 64;
  localparam int POOL_N      = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 400;

  // Register map: one register, at byte address 4 * index.
  localparam int             REG_CAPACITY  = 0;
  localparam logic [2:0]     CAPACITY_ADDR = 3'(4 * REG_CAPACITY);
  // The encoding left free by action_t; the block treats it as a check.
  localparam logic [akt_pkg::ACT_W-1:0] ACT_UNUSED  = 2'd3;
  localparam logic [akt_pkg::KEY_W-1:0] KEY_ALL_ONE = '1;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  akt_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  akt_pkg::out_item_t out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  allowlist_key_table_core #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: our own copy of the table, the entry count and the capacity.
  logic [akt_pkg::KEY_W-1:0] allow_keys [TABLE_DEPTH];
  int                        allow_count;
  logic [akt_pkg::CNT_W-1:0] capacity_reg;
  int                        peak_count;

  akt_pkg::in_item_t         request_queue [$];    // requests waiting to be offered
  akt_pkg::out_item_t        expected_results [$]; // answers owed by the block, oldest first
  logic [akt_pkg::KEY_W-1:0] key_pool [POOL_N];

  int n_queued;
  int n_accepted;
  int n_results;
  int err_count;
  int status_seen [4];

  // Work out one request's answer and advance the predicted table.
  function automatic akt_pkg::out_item_t lookup_and_update(input akt_pkg::in_item_t req);
    akt_pkg::out_item_t ans;
    int                 lim;
    int                 hit;
    lim = (int'(capacity_reg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
    hit = -1;
    for (int i = 0; i < allow_count; i++) begin
      if (hit < 0 && allow_keys[i] == req.key) hit = i;
    end
    case (req.action)
      akt_pkg::ACT_INSERT: begin
        if (hit >= 0) begin
          ans.status = akt_pkg::ST_DUP;
        end else if (allow_count >= lim) begin
          ans.status = akt_pkg::ST_FULL;
        end else begin
          allow_keys[allow_count] = req.key;
          allow_count++;
          ans.status = akt_pkg::ST_OK;
        end
      end
      akt_pkg::ACT_REPLACE: begin
        // Overwrite only the lowest matching slot; duplicates of the new key are allowed.
        if (hit >= 0) begin
          allow_keys[hit] = req.replacement_key;
          ans.status = akt_pkg::ST_OK;
        end else begin
          ans.status = akt_pkg::ST_ABSENT;
        end
      end
      default: ans.status = (hit >= 0) ? akt_pkg::ST_OK : akt_pkg::ST_ABSENT;
    endcase
    ans.entry_count = akt_pkg::CNT_W'(allow_count);
    if (allow_count > peak_count) peak_count = allow_count;
    return ans;
  endfunction

  // Sender gap after a transfer: mostly none, some short, a few long.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Keys drawn mostly from a small pool so that hits, duplicates and replaces happen.
  function automatic logic [akt_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 65) return key_pool[$urandom_range(0, POOL_N - 1)];
    return akt_pkg::KEY_W'($urandom);
  endfunction

  task automatic add_request(input logic [akt_pkg::ACT_W-1:0] act,
                             input logic [akt_pkg::KEY_W-1:0] k,
                             input logic [akt_pkg::KEY_W-1:0] rk);
    akt_pkg::in_item_t req;
    req.action = act;
    req.key = k;
    req.replacement_key = rk;
    request_queue.push_back(req);
    n_queued++;
  endtask

  task automatic add_random(input int count, input int insert_pct);
    int                        r;
    logic [akt_pkg::ACT_W-1:0] act;
    logic [akt_pkg::KEY_W-1:0] rk;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) act = akt_pkg::ACT_INSERT;
      else if (r < insert_pct + (100 - insert_pct) * 45 / 100) act = akt_pkg::ACT_CHECK;
      else if (r < 95) act = akt_pkg::ACT_REPLACE;
      else act = ACT_UNUSED;
      rk = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, POOL_N - 1)]
                                      : akt_pkg::KEY_W'($urandom);
      add_request(act, pick_key(), rk);
    end
  endtask

  // Block until every queued request has transferred and every answer has come back.
  task automatic wait_idle();
    @(negedge clk);
    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write of the capacity register, then read it back.
  task automatic write_capacity(input logic [akt_pkg::CNT_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The write lands at this edge; switch straight into the read setup.
    capacity_reg = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[akt_pkg::CNT_W-1:0] !== value) begin
      $display("%0t: capacity readback expected %0d got %0d", $time, value,
               prdata[akt_pkg::CNT_W-1:0]);
      err_count++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver: offer queued requests, hold a stalled transfer, predict on acceptance.
  always @(posedge clk) begin : drive_requests
    int  gap_left;
    logic took;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        expected_results.push_back(lookup_and_update(in_data));
        n_accepted++;
      end
      if (in_valid && !took) begin
        // Hold the stalled payload as it is.
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        in_data <= request_queue.pop_front();
        in_valid <= 1'b1;
        gap_left = sender_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver: check each result transfer, stall in random stretches.
  always @(posedge clk) begin : take_results
    int                 stretch_left;
    int                 r;
    logic               long_hold_done;
    akt_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stretch_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        status_seen[out_data.status]++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d count %0d", $time,
                   out_data.status, out_data.entry_count);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_data.status);
            err_count++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                     out_data.entry_count);
            err_count++;
          end
        end
      end
      if (stretch_left != 0) begin
        stretch_left--;
      end else if (!long_hold_done && n_results >= 30) begin
        // Hold off for a long stretch once so the sender backs up against in_stall.
        out_stall <= 1'b1;
        stretch_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          stretch_left = $urandom_range(0, 20);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          stretch_left = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          stretch_left = $urandom_range(10, 80);
        end
      end
    end
  end

  // Watchdog: drop the run if it overruns the cycle budget.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    allow_count = 0;
    peak_count = 0;
    capacity_reg = akt_pkg::CAPACITY_RESET;
    n_queued = 0;
    n_accepted = 0;
    n_results = 0;
    err_count = 0;
    for (int s = 0; s < 4; s++) status_seen[s] = 0;
    for (int i = 0; i < POOL_N; i++) key_pool[i] = akt_pkg::KEY_W'($urandom);
    for (int i = 0; i < TABLE_DEPTH; i++) allow_keys[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, duplicates, field extremes, the unused action code,
    // and replaces that create a duplicate and then hit the lower copy.
    add_request(akt_pkg::ACT_CHECK,   '0,          KEY_ALL_ONE);
    add_request(akt_pkg::ACT_REPLACE, '0,          KEY_ALL_ONE);
    add_request(akt_pkg::ACT_INSERT,  '0,          KEY_ALL_ONE);
    add_request(akt_pkg::ACT_INSERT,  '0,          '0);
    add_request(akt_pkg::ACT_INSERT,  KEY_ALL_ONE, '0);
    add_request(akt_pkg::ACT_CHECK,   KEY_ALL_ONE, '0);
    add_request(ACT_UNUSED,           '0,          KEY_ALL_ONE);
    add_request(ACT_UNUSED,           KEY_ALL_ONE, 22'h155555);
    add_request(akt_pkg::ACT_CHECK,   22'h155555,  '0);
    add_request(akt_pkg::ACT_REPLACE, KEY_ALL_ONE, '0);
    add_request(akt_pkg::ACT_REPLACE, '0,          22'h155555);
    add_request(akt_pkg::ACT_CHECK,   '0,          KEY_ALL_ONE);
    add_request(akt_pkg::ACT_CHECK,   KEY_ALL_ONE, KEY_ALL_ONE);
    add_request(akt_pkg::ACT_INSERT,  22'h2AAAAA,  22'h155555);
    add_request(akt_pkg::ACT_REPLACE, 22'h123456,  22'h2AAAAA);
    wait_idle();

    // Capacity zero, below the current count: new keys are full, known keys duplicate.
    write_capacity(7'd0);
    add_request(akt_pkg::ACT_INSERT, 22'h0F0F0F, '0);
    add_request(akt_pkg::ACT_INSERT, 22'h155555, '0);
    add_random(60, 40);
    wait_idle();

    write_capacity(7'd8);
    add_random(120, 40);
    wait_idle();

    // Above the built depth: the table should stop at TABLE_DEPTH entries.
    write_capacity(7'd127);
    add_random(250, 60);
    wait_idle();

    write_capacity(7'd20);
    add_random(120, 35);
    wait_idle();

    write_capacity(7'd64);
    add_random(250, 35);
    wait_idle();

    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      err_count++;
    end

    $display("Covered %0d requests and %0d results over six capacity settings, peak %0d entries.",
             n_accepted, n_results, peak_count);
    $display("Status mix: ok %0d, absent %0d, duplicate %0d, full %0d.",
             status_seen[akt_pkg::ST_OK], status_seen[akt_pkg::ST_ABSENT],
             status_seen[akt_pkg::ST_DUP], status_seen[akt_pkg::ST_FULL]);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
